// File: design/itoa_pkg.sv
// Shared types and constants for the integer-to-ASCII formatter.
package itoa_pkg;

  // Format selector codes
  localparam logic [1:0] FMT_DEC  = 2'd0;
  localparam logic [1:0] FMT_HEXL = 2'd1;
  localparam logic [1:0] FMT_HEXU = 2'd2;

  // Character constants
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] LOWER_BASE = 8'd96;
  localparam logic [7:0] UPPER_BASE = 8'd64;

  // Digit geometry
  localparam int VALUE_W    = 64;
  localparam int DIGITS_MAX = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = DIGITS_MAX * DIGIT_W;
  localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
  localparam int BITS_STEP  = 4;
  localparam int DD_STEPS   = VALUE_W / BITS_STEP;

  // Classified item passed from front to back
  typedef struct packed {
    logic                is_dec;
    logic                upper;
    logic                neg;
    logic [VALUE_W-1:0]  mag;
  } itoa_entry_t;

endpackage

// File: design/itoa_front.sv
// Front end: accepts a transaction and classifies format, sign and magnitude.
module itoa_front (
  input  logic                  start,
  input  logic [1:0]            in_action,
  input  logic [63:0]           in_value,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output itoa_pkg::itoa_entry_t entry
);
  import itoa_pkg::*;

  // Hold intake off while the queue is full
  assign busy = q_full;
  assign push = start & ~q_full;

  // Decode the format selector; the unused code acts as uppercase hex
  always_comb begin
    entry = '0;
    unique case (in_action)
      FMT_DEC: begin
        entry.is_dec = 1'b1;
        entry.upper  = 1'b0;
        entry.neg    = in_value[VALUE_W-1];
      end
      FMT_HEXL: begin
        entry.is_dec = 1'b0;
        entry.upper  = 1'b0;
        entry.neg    = 1'b0;
      end
      default: begin
        entry.is_dec = 1'b0;
        entry.upper  = 1'b1;
        entry.neg    = 1'b0;
      end
    endcase
    // Take the unsigned magnitude of negative decimal values
    entry.mag = entry.neg ? (~in_value + 64'd1) : in_value;
  end

endmodule

// File: design/itoa_queue.sv
// Small register queue between the front end and the digit engine.
module itoa_queue #(
  parameter int DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  itoa_pkg::itoa_entry_t         push_data,
  input  logic                          pop,
  output itoa_pkg::itoa_entry_t         pop_data,
  output logic                          full,
  output logic                          not_empty,
  output logic [$clog2(DEPTH+1)-1:0]    level
);
  import itoa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  itoa_entry_t            mem_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign level     = cnt_r;
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the payload slot
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/itoa_back.sv
// Back end: converts a magnitude to digits, emits one char per cycle once begun.
module itoa_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  itoa_pkg::itoa_entry_t q_data,
  output logic                  q_pop,
  output logic                  out_strobe,
  output logic [7:0]            out_char_code,
  output logic                  out_last_char
);
  import itoa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int STEP_W = $clog2(DD_STEPS);
  localparam int CNT_W  = $clog2(DIGITS_MAX+1);

  logic [1:0]          state_r, state_nxt;
  logic [BCD_W-1:0]    digits_r, digits_nxt;
  logic [VALUE_W-1:0]  bin_r, bin_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                is_dec_r, is_dec_nxt;
  logic                upper_r, upper_nxt;
  logic                neg_r, neg_nxt;
  logic                started_r, started_nxt;
  logic                strobe_r, strobe_nxt;
  logic [7:0]          char_r, char_nxt;
  logic                last_r, last_nxt;
  logic [DIGIT_W-1:0]  top_digit;
  logic [7:0]          digit_char;
  logic                final_pos;

  // Shift BITS_STEP binary bits into the BCD register, adjusting digits first
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                              input logic [BITS_STEP-1:0] bits);
    logic [BCD_W-1:0]   acc;
    logic [DIGIT_W-1:0] dg;
    acc = bcd;
    for (int b = BITS_STEP-1; b >= 0; b--) begin
      for (int i = 0; i < DIGITS_MAX; i++) begin
        dg = acc[i*DIGIT_W +: DIGIT_W];
        if (dg >= 4'd5) begin
          acc[i*DIGIT_W +: DIGIT_W] = dg + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bits[b]};
    end
    return acc;
  endfunction

  assign top_digit = digits_r[BCD_W-1 -: DIGIT_W];
  assign final_pos = (cnt_r == CNT_W'(1));
  assign q_pop     = (state_r == ST_IDLE) & q_not_empty;

  // Map one digit to its character
  always_comb begin
    if (is_dec_r || top_digit <= 4'd9) begin
      digit_char = CHAR_ZERO + {4'd0, top_digit};
    end else begin
      digit_char = (upper_r ? UPPER_BASE : LOWER_BASE) + {4'd0, top_digit} - 8'd9;
    end
  end

  // Sequence conversion and emission
  always_comb begin
    state_nxt   = state_r;
    digits_nxt  = digits_r;
    bin_nxt     = bin_r;
    step_nxt    = step_r;
    cnt_nxt     = cnt_r;
    is_dec_nxt  = is_dec_r;
    upper_nxt   = upper_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    strobe_nxt  = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          is_dec_nxt  = q_data.is_dec;
          upper_nxt   = q_data.upper;
          neg_nxt     = q_data.neg;
          started_nxt = 1'b0;
          if (q_data.is_dec) begin
            digits_nxt = '0;
            bin_nxt    = q_data.mag;
            step_nxt   = '0;
            state_nxt  = ST_CONV;
          end else begin
            digits_nxt = {q_data.mag, (BCD_W-VALUE_W)'(0)};
            cnt_nxt    = CNT_W'(HEX_DIGITS);
            state_nxt  = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        digits_nxt = dabble(digits_r, bin_r[VALUE_W-1 -: BITS_STEP]);
        bin_nxt    = {bin_r[VALUE_W-BITS_STEP-1:0], BITS_STEP'(0)};
        step_nxt   = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DD_STEPS-1)) begin
          cnt_nxt   = CNT_W'(DIGITS_MAX);
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = CHAR_MINUS;
        last_nxt   = 1'b0;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // Drop leading zeros, but always keep the final digit
        if (started_r || top_digit != '0 || final_pos) begin
          strobe_nxt  = 1'b1;
          char_nxt    = digit_char;
          last_nxt    = final_pos;
          started_nxt = 1'b1;
        end
        digits_nxt = {digits_r[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (final_pos) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      strobe_r  <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      strobe_r  <= strobe_nxt;
      started_r <= started_nxt;
    end
  end

  // Hold the datapath registers
  always_ff @(posedge clk) begin
    digits_r <= digits_nxt;
    bin_r    <= bin_nxt;
    step_r   <= step_nxt;
    cnt_r    <= cnt_nxt;
    is_dec_r <= is_dec_nxt;
    upper_r  <= upper_nxt;
    neg_r    <= neg_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

endmodule

// File: design/integer_to_ascii_digits_core.sv
// Top level of the integer-to-ASCII formatter: front end, queue and digit engine.
//
//  channel  ports                               handshake
//  -------  ----------------------------------  ---------------------------------
//  input    in_action[1:0], in_value[63:0]      accepted when start && !busy
//  result   out_char_code[7:0], out_last_char   out_strobe high for one cycle
//
// Decimal: pop the item, run double dabble (4 bits a cycle), emit a minus
// sign if negative, then scan every BCD position. Hex: pop, then scan nibbles.
// The digit engine sets the rate and takes a new item only after finishing
// the last one; the queue ahead of it holds up to QUEUE_DEPTH items.
// Reset is synchronous, active low, and empties the queue and the engine.
// busy rises only when the queue is full; results cannot be held off.
module integer_to_ascii_digits_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_value,
  output logic        out_strobe,
  output logic [7:0]  out_char_code,
  output logic        out_last_char
);
  import itoa_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

  itoa_entry_t       front_entry;
  itoa_entry_t       q_data;
  logic              push;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  logic [LVL_W-1:0]  q_level;

  itoa_front u_front (
    .start     (start),
    .in_action (in_action),
    .in_value  (in_value),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .entry     (front_entry)
  );

  itoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  itoa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // Queue occupancy never exceeds its depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= LVL_W'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // After the final character of a number, no character follows in the next cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_char |=> !out_strobe)
    else $error("character right after final character");

  // A minus sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_char_code == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign marked as final character");

  // Busy only when the queue holds as many items as it can
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_level == LVL_W'(QUEUE_DEPTH))
    else $error("busy with room in the queue");

endmodule

// File: bench/ascii_digit_checker.sv
`timescale 1ns / 100ps
// Checker for the integer-to-ASCII formatter: predicts the character stream and compares.
module ascii_digit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_value,
  input  logic        out_strobe,
  input  logic [7:0]  out_char_code,
  input  logic        out_last_char,
  output int unsigned fail_count,
  output int unsigned chars_due
);
  import itoa_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } text_char_t;

  // Characters still owed by the block, oldest first
  text_char_t expected_text[$];

  task automatic report_mismatch(input string what);
    if (fail_count < 100) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    fail_count++;
  endtask

  // Append the characters of one number to the expected stream
  function automatic void predict_text(input logic [1:0] fmt, input logic [63:0] bits);
    logic [7:0]  rev [DIGITS_MAX];
    int          n;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] digit;
    logic [7:0]  letter_base;
    text_char_t  ch;
    n   = 0;
    neg = 1'b0;
    if (fmt == FMT_DEC) begin
      // Take the magnitude as unsigned so the most negative value survives
      neg = bits[63];
      mag = neg ? (~bits + 64'd1) : bits;
      if (mag == 64'd0) begin
        rev[n] = CHAR_ZERO;
        n++;
      end
      while (mag != 64'd0 && n < DIGITS_MAX) begin
        digit  = mag % 64'd10;
        rev[n] = CHAR_ZERO + digit[7:0];
        n++;
        mag = mag / 64'd10;
      end
    end else begin
      // Unused selector falls through to uppercase
      letter_base = (fmt == FMT_HEXL) ? LOWER_BASE : UPPER_BASE;
      mag = bits;
      if (mag == 64'd0) begin
        rev[n] = CHAR_ZERO;
        n++;
      end
      while (mag != 64'd0 && n < DIGITS_MAX) begin
        digit = {60'd0, mag[3:0]};
        if (digit > 64'd9) begin
          rev[n] = digit[7:0] - 8'd9 + letter_base;
        end else begin
          rev[n] = CHAR_ZERO + digit[7:0];
        end
        n++;
        mag = mag >> 4;
      end
    end
    if (neg) begin
      ch.code    = CHAR_MINUS;
      ch.is_last = 1'b0;
      expected_text.push_back(ch);
    end
    for (int k = n - 1; k >= 0; k--) begin
      ch.code    = rev[k];
      ch.is_last = (k == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // Predict on each accepted transaction, compare each strobed character
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      expected_text.delete();
    end else begin
      if (start && !busy) begin
        predict_text(in_action, in_value);
      end
      if (out_strobe) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    out_char_code, out_last_char));
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                      out_char_code, want.code));
          end
          if (out_last_char !== want.is_last) begin
            report_mismatch($sformatf("last_char %0b, want %0b (char 0x%02h)",
                                      out_last_char, want.is_last, want.code));
          end
        end
      end
    end
    chars_due <= expected_text.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the integer-to-ASCII formatter: stimulus, timeout and verdict.
module tb_top;
  import itoa_pkg::*;

  // Spare selector code, expected to format as uppercase hex
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_action = FMT_DEC;
  logic [63:0] in_value = 64'd0;
  logic        busy;
  logic        out_strobe;
  logic [7:0]  out_char_code;
  logic        out_last_char;
  int unsigned fail_count;
  int unsigned chars_due;
  int unsigned cycle_count = 0;
  logic        burst_mode = 1'b0;

  always #4 clk = ~clk;

  integer_to_ascii_digits_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  ascii_digit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .fail_count    (fail_count),
    .chars_due     (chars_due)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold start until the block takes the transaction
  task automatic send_number(input logic [1:0] fmt, input logic [63:0] bits);
    in_action <= fmt;
    in_value  <= bits;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 94) return $urandom_range(5, 25);
    return $urandom_range(30, 90);
  endfunction

  // Lower start for the gap and wiggle the idle payload
  task automatic idle_gap(input int gap);
    if (gap > 0) begin
      start     <= 1'b0;
      in_action <= 2'($urandom);
      in_value  <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // Values biased toward digit-count boundaries and sign edges
  function automatic logic [63:0] pick_value();
    logic [63:0] p;
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: p = r;
      2: p = 64'($urandom_range(0, 255));
      3: p = ~64'($urandom_range(0, 1000)) + 64'd1;
      4: begin
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        p = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      5: p = (64'd1 << (4 * $urandom_range(0, 15))) - 64'($urandom_range(0, 1));
      6: p = r >> $urandom_range(0, 63);
      default: p = r | ({64{1'b1}} << $urandom_range(1, 63));
    endcase
    return p;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, sign edges, digit-count edges, all formats
    send_number(FMT_DEC,   64'd0);
    send_number(FMT_DEC,   64'd1);
    send_number(FMT_DEC,   64'hFFFF_FFFF_FFFF_FFFF);
    send_number(FMT_DEC,   64'd9);
    send_number(FMT_DEC,   64'd10);
    send_number(FMT_DEC,   64'h7FFF_FFFF_FFFF_FFFF);
    send_number(FMT_DEC,   64'h8000_0000_0000_0000);
    send_number(FMT_DEC,   64'd999999999999999999);
    send_number(FMT_DEC,   64'd1000000000000000000);
    send_number(FMT_DEC,   64'hFFFF_FFFF_FFFF_FFF6);
    send_number(FMT_HEXL,  64'd0);
    send_number(FMT_HEXL,  64'd1);
    send_number(FMT_HEXL,  64'hFFFF_FFFF_FFFF_FFFF);
    send_number(FMT_HEXL,  64'h0123_4567_89AB_CDEF);
    send_number(FMT_HEXL,  64'hFEDC_BA98_7654_3210);
    send_number(FMT_HEXU,  64'd0);
    send_number(FMT_HEXU,  64'hFFFF_FFFF_FFFF_FFFF);
    send_number(FMT_HEXU,  64'h0123_4567_89AB_CDEF);
    send_number(FMT_HEXU,  64'hFEDC_BA98_7654_3210);
    send_number(FMT_HEXU,  64'h8000_0000_0000_0000);
    send_number(FMT_SPARE, 64'h0000_0000_00AB_CDEF);
    send_number(FMT_SPARE, 64'd0);
    idle_gap(pick_gap());

    // Random formats and values with random idling
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 32 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      send_number(2'($urandom_range(0, 3)), pick_value());
      idle_gap(pick_gap());
    end
    start <= 1'b0;

    // Drain, then give stray characters time to show up
    while (chars_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && chars_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
